FILE: hw/rtl/fcrm_pkg.sv
// Shared types and constants for the filled circle row mask block.
`timescale 1ns / 1ps

package fcrm_pkg;

    localparam int unsigned CoordWidth  = 16;
    localparam int unsigned RadiusWidth = 5;
    localparam int unsigned ColourWidth = 16;
    localparam int unsigned MaskWidth   = 63;
    localparam int unsigned SquareWidth = 2 * RadiusWidth;
    localparam int unsigned DefaultMaxRadius = 31;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;   // capture a new request
        logic issue;  // start the next row
    } fcrm_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic advance;       // row pipeline moves this cycle
        logic issue_final;   // the row about to be issued is the bottom row
        logic final_taken;   // bottom row item taken at the output
    } fcrm_stat_t;

endpackage

FILE: hw/rtl/fcrm_ctrl.sv
// Controller state machine that sequences the rows of one draw request.
`timescale 1ns / 1ps

module fcrm_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output fcrm_pkg::fcrm_cmd_t cmd,
    input  fcrm_pkg::fcrm_stat_t stat
);
    import fcrm_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_ISSUE = 3'b010,
        ST_DRAIN = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE:
            begin
                if (stat.advance)
                begin
                    cmd.issue = 1'b1;
                    if (stat.issue_final)
                    begin
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN:
            begin
                if (stat.final_taken)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: hw/rtl/fcrm_datapath.sv
// Datapath: request registers, row counter, span limit stage and mask output stage.
`timescale 1ns / 1ps

module fcrm_datapath #(
    parameter int unsigned MAX_RADIUS = fcrm_pkg::DefaultMaxRadius
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic signed [fcrm_pkg::CoordWidth-1:0]   center_x,
    input  logic signed [fcrm_pkg::CoordWidth-1:0]   center_y,
    input  logic        [fcrm_pkg::RadiusWidth-1:0]  radius,
    input  logic        [fcrm_pkg::ColourWidth-1:0]  pixel_colour,
    input  fcrm_pkg::fcrm_cmd_t                      cmd,
    output fcrm_pkg::fcrm_stat_t                     stat,
    output logic                                     out_valid,
    input  logic                                     out_ready,
    output logic signed [fcrm_pkg::CoordWidth-1:0]   row_y,
    output logic signed [fcrm_pkg::CoordWidth-1:0]   left_x,
    output logic        [fcrm_pkg::MaskWidth-1:0]    row_mask,
    output logic        [fcrm_pkg::ColourWidth-1:0]  span_colour,
    output logic                                     last_row
);
    import fcrm_pkg::*;

    localparam logic [RadiusWidth-1:0] RadiusCap = RadiusWidth'(MAX_RADIUS);

    // Request registers, stable for the whole request.
    logic        [RadiusWidth-1:0] rad_reg;
    logic        [SquareWidth-1:0] rad_sq_reg;
    logic        [CoordWidth-1:0]  cy_reg;
    logic        [CoordWidth-1:0]  left_reg;
    logic        [ColourWidth-1:0] colour_reg;

    // Row counter, dy from -r to +r.
    logic signed [RadiusWidth:0]   dy_reg;

    // Limit stage.
    logic                          v1_reg;
    logic        [SquareWidth-1:0] lim_reg;
    logic        [CoordWidth-1:0]  row1_reg;
    logic                          last1_reg;

    // Output stage.
    logic                          out_valid_reg;
    logic        [CoordWidth-1:0]  row_out_reg;
    logic        [MaskWidth-1:0]   mask_out_reg;
    logic                          last_out_reg;

    logic        [RadiusWidth-1:0] rad_sat;
    logic        [RadiusWidth-1:0] ady;
    logic        [SquareWidth-1:0] ady_sq;
    logic        [SquareWidth-1:0] lim_next;
    logic        [(1<<RadiusWidth)-1:0] in_span;
    logic        [MaskWidth-1:0]   mask_next;
    logic                          advance;
    logic                          dy_final;

    assign rad_sat  = (radius > RadiusCap) ? RadiusCap : radius;
    assign advance  = !out_valid_reg || out_ready;
    assign dy_final = (dy_reg == $signed({1'b0, rad_reg}));

    assign ady      = dy_reg[RadiusWidth] ? RadiusWidth'(-dy_reg) : dy_reg[RadiusWidth-1:0];
    assign ady_sq   = ady * ady;
    assign lim_next = rad_sq_reg - ady_sq;

    // Offset k lies inside the span when k*k fits under the row limit.
    always_comb
    begin
        for (int k = 0; k < (1 << RadiusWidth); k++)
        begin
            in_span[k] = (SquareWidth'(k * k) <= lim_reg);
        end
    end

    always_comb
    begin
        logic [RadiusWidth:0] offs;
        for (int i = 0; i < MaskWidth; i++)
        begin
            if ((RadiusWidth+1)'(i) >= {1'b0, rad_reg})
            begin
                offs = (RadiusWidth+1)'(i) - {1'b0, rad_reg};
            end
            else
            begin
                offs = {1'b0, rad_reg} - (RadiusWidth+1)'(i);
            end
            mask_next[i] = !offs[RadiusWidth] && in_span[offs[RadiusWidth-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            rad_reg    <= rad_sat;
            rad_sq_reg <= rad_sat * rad_sat;
            cy_reg     <= center_y;
            left_reg   <= center_x - CoordWidth'(rad_sat);
            colour_reg <= pixel_colour;
            dy_reg     <= -$signed({1'b0, rad_sat});
        end
        else if (cmd.issue)
        begin
            dy_reg <= dy_reg + 1'b1;
        end

        if (advance && cmd.issue)
        begin
            lim_reg   <= lim_next;
            row1_reg  <= cy_reg + CoordWidth'(dy_reg);
            last1_reg <= dy_final;
        end

        if (advance && v1_reg)
        begin
            row_out_reg  <= row1_reg;
            mask_out_reg <= mask_next;
            last_out_reg <= last1_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            v1_reg        <= cmd.issue;
            out_valid_reg <= v1_reg;
        end
    end

    assign stat.advance     = advance;
    assign stat.issue_final = dy_final;
    assign stat.final_taken = out_valid_reg && out_ready && last_out_reg;

    assign out_valid   = out_valid_reg;
    assign row_y       = row_out_reg;
    assign left_x      = left_reg;
    assign row_mask    = mask_out_reg;
    assign span_colour = colour_reg;
    assign last_row    = last_out_reg;

endmodule

FILE: hw/rtl/filled_circle_row_masks_top.sv
// Top level of the filled circle row mask block.
`timescale 1ns / 1ps

// Usage: one draw request item (center_x, center_y, radius, pixel_colour) is taken
// on the input channel when in_valid and in_ready are both high. A radius above
// MAX_RADIUS is clamped to it. The block then emits 2r+1 row items, top row first,
// each with row_y, left_x, a 63-bit row_mask, span_colour and last_row, which is
// set on the bottom row only.
// Timing: the first row item becomes valid once it has passed the limit and mask stages.
// Rows follow at one per cycle while out_ready stays high; the row counter, a
// limit stage (r*r - dy*dy) and a mask stage form a two-deep row pipeline.
// A request therefore keeps the block busy from acceptance until its bottom row
// item is taken at the output.
// in_ready is high only when no row of the previous request is outstanding.
// A stall on out_ready freezes the row pipeline; the waiting row item stays on
// the output ports unchanged until it is taken.
// Reset clears the controller and the pipeline valid bits; the block then waits
// for a request.

module filled_circle_row_masks_top #(
    parameter int unsigned MAX_RADIUS = fcrm_pkg::DefaultMaxRadius
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     in_valid,
    output logic                                     in_ready,
    input  logic signed [fcrm_pkg::CoordWidth-1:0]   center_x,
    input  logic signed [fcrm_pkg::CoordWidth-1:0]   center_y,
    input  logic        [fcrm_pkg::RadiusWidth-1:0]  radius,
    input  logic        [fcrm_pkg::ColourWidth-1:0]  pixel_colour,
    output logic                                     out_valid,
    input  logic                                     out_ready,
    output logic signed [fcrm_pkg::CoordWidth-1:0]   row_y,
    output logic signed [fcrm_pkg::CoordWidth-1:0]   left_x,
    output logic        [fcrm_pkg::MaskWidth-1:0]    row_mask,
    output logic        [fcrm_pkg::ColourWidth-1:0]  span_colour,
    output logic                                     last_row
);
    import fcrm_pkg::*;

    fcrm_cmd_t  cmd;
    fcrm_stat_t stat;

    fcrm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .cmd      (cmd),
        .stat     (stat)
    );

    fcrm_datapath #(
        .MAX_RADIUS (MAX_RADIUS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .center_x     (center_x),
        .center_y     (center_y),
        .radius       (radius),
        .pixel_colour (pixel_colour),
        .cmd          (cmd),
        .stat         (stat),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .row_y        (row_y),
        .left_x       (left_x),
        .row_mask     (row_mask),
        .span_colour  (span_colour),
        .last_row     (last_row)
    );

`ifndef SYNTHESIS
    // A new request is never taken while rows of the previous one are pending.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("request taken while rows still pending");

    // Once the bottom row is taken, the block is free for the next request.
    a_free_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && last_row) |=> in_ready)
        else $error("block not free after bottom row");

    // A taken request keeps the block busy until its rows are out.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("block free right after taking a request");
`endif

endmodule
